// File: rtl/rlhe_pkg.sv
// ----------------------------------------------------------------------------
// rlhe_pkg
// Shared types, constants and the code table of the run-level VLC encoder.
// ----------------------------------------------------------------------------
package rlhe_pkg;

    localparam int BLOCK_COEFS_DEF = 64;

    // field widths
    localparam int RUN_W   = 7;
    localparam int LEVEL_W = 16;
    localparam int BITS_W  = 16;
    localparam int LEN_W   = 5;
    localparam int SUM_W   = 8;    // position + run + 1 never wraps here

    // fixed codewords, already shifted left by one
    localparam logic [6:0] EOS_CHUNK     = 7'h74;
    localparam logic [2:0] EOS_CHUNK_LEN = 3'd7;
    localparam logic [6:0] ESC_CODE      = 7'h60;
    localparam logic [4:0] ESC_LEN       = 5'd7;
    localparam logic [5:0] RUN_SAT       = 6'd63;

    // escape chunk order
    localparam logic [2:0] CH_SIGN = 3'd0;
    localparam logic [2:0] CH_ESC  = 3'd1;
    localparam logic [2:0] CH_RUN  = 3'd2;
    localparam logic [2:0] CH_MAG  = 3'd3;
    localparam logic [2:0] CH_LAST = 3'd4;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
        logic [2:0] len;
    } t_lookup;

    // one encoded word waiting to be split into chunks
    typedef struct packed {
        logic         esc;
        logic [6:0]   sbits;    // single chunk value
        logic [2:0]   slen;     // single chunk length
        logic         sign;
        logic [5:0]   run;
        logic [15:0]  mag;
        logic         last;
        logic         done;
    } t_item;

    function automatic t_lookup code_lookup(input logic [6:0] run,
                                            input logic [15:0] mag,
                                            input logic last);
        t_lookup r;
        r = '{hit: 1'b1, code: 6'h00, len: 3'd0};
        if      (run == 7'd0 && mag == 16'd1 && !last) begin r.code = 6'h01; r.len = 3'd2; end
        else if (run == 7'd1 && mag == 16'd1 && !last) begin r.code = 6'h03; r.len = 3'd3; end
        else if (run == 7'd2 && mag == 16'd1 && !last) begin r.code = 6'h07; r.len = 3'd4; end
        else if (run == 7'd0 && mag == 16'd2 && !last) begin r.code = 6'h0f; r.len = 3'd4; end
        else if (run == 7'd0 && mag == 16'd1 &&  last) begin r.code = 6'h0e; r.len = 3'd4; end
        else if (run == 7'd3 && mag == 16'd1 && !last) begin r.code = 6'h16; r.len = 3'd5; end
        else if (run == 7'd4 && mag == 16'd1 && !last) begin r.code = 6'h06; r.len = 3'd5; end
        else if (run == 7'd5 && mag == 16'd1 && !last) begin r.code = 6'h1a; r.len = 3'd5; end
        else if (run == 7'd0 && mag == 16'd3 && !last) begin r.code = 6'h2a; r.len = 3'd6; end
        else r.hit = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/rlhe_enc.sv
// ----------------------------------------------------------------------------
// rlhe_enc
// Table match, escape fields and block position update for one word.
// ----------------------------------------------------------------------------
module rlhe_enc #(
    parameter int BLOCK_COEFS = rlhe_pkg::BLOCK_COEFS_DEF,
    localparam int POS_W      = $clog2(BLOCK_COEFS)
) (
    input  logic                  i_req_type,
    input  logic [6:0]            i_run_length,
    input  logic signed [15:0]    i_level_value,
    input  logic                  i_last_flag,
    input  logic [POS_W-1:0]      i_pos,
    output rlhe_pkg::t_item       o_item,
    output logic [POS_W-1:0]      o_pos_next
);

    localparam int SW = rlhe_pkg::SUM_W;

    logic            sign;
    logic [15:0]     mag;
    logic [SW-1:0]   sum;
    logic            done;
    rlhe_pkg::t_lookup lk;

    assign sign = i_level_value[15];
    assign mag  = sign ? (16'd0 - i_level_value) : i_level_value;
    assign lk   = rlhe_pkg::code_lookup(i_run_length, mag, i_last_flag);

    assign sum  = {{(SW-POS_W){1'b0}}, i_pos} + {1'b0, i_run_length} + SW'(1);
    assign done = i_last_flag || (sum >= SW'(BLOCK_COEFS));

    // end-of-stream leaves the position alone
    assign o_pos_next = i_req_type ? i_pos : (done ? '0 : sum[POS_W-1:0]);

    always_comb begin
        o_item       = '0;
        o_item.sign  = sign;
        o_item.mag   = mag;
        o_item.last  = i_last_flag;
        o_item.run   = (i_run_length >= {1'b0, rlhe_pkg::RUN_SAT}) ?
                       rlhe_pkg::RUN_SAT : i_run_length[5:0];
        if (i_req_type) begin
            o_item.sbits = rlhe_pkg::EOS_CHUNK;
            o_item.slen  = rlhe_pkg::EOS_CHUNK_LEN;
            o_item.done  = 1'b0;
        end else begin
            o_item.esc   = !lk.hit;
            o_item.sbits = {lk.code, sign};
            o_item.slen  = lk.len + 3'd1;
            o_item.done  = done;
        end
    end

endmodule

// File: rtl/rlhe_out.sv
// ----------------------------------------------------------------------------
// rlhe_out
// Result register: holds one encoded word and hands out its chunks.
// ----------------------------------------------------------------------------
module rlhe_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rlhe_pkg::t_item  i_item,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [15:0]      o_chunk_bits,
    output logic [4:0]       o_chunk_len,
    output logic             o_last_chunk,
    output logic             o_block_done
);

    logic            r_valid, n_valid;
    logic [2:0]      r_idx, n_idx;
    rlhe_pkg::t_item r_item;
    logic            fin;

    assign fin     = !r_item.esc || (r_idx == rlhe_pkg::CH_LAST);
    assign o_take  = !r_valid || (i_ready && fin);
    assign o_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_take) begin
            n_valid = i_load;
            n_idx   = rlhe_pkg::CH_SIGN;
        end else if (i_ready) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= rlhe_pkg::CH_SIGN;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_load) begin
            r_item <= i_item;
        end
    end

    // chunk select
    always_comb begin
        o_chunk_bits = '0;
        o_chunk_len  = '0;
        o_last_chunk = 1'b0;
        o_block_done = 1'b0;
        if (!r_item.esc) begin
            o_chunk_bits = {9'd0, r_item.sbits};
            o_chunk_len  = {2'd0, r_item.slen};
            o_last_chunk = 1'b1;
            o_block_done = r_item.done;
        end else begin
            case (r_idx)
                rlhe_pkg::CH_SIGN: begin
                    o_chunk_bits = {15'd0, r_item.sign};
                    o_chunk_len  = 5'd1;
                end
                rlhe_pkg::CH_ESC: begin
                    o_chunk_bits = {9'd0, rlhe_pkg::ESC_CODE};
                    o_chunk_len  = rlhe_pkg::ESC_LEN;
                end
                rlhe_pkg::CH_RUN: begin
                    o_chunk_bits = {10'd0, r_item.run};
                    o_chunk_len  = 5'd6;
                end
                rlhe_pkg::CH_MAG: begin
                    o_chunk_bits = r_item.mag;
                    o_chunk_len  = 5'd16;
                end
                rlhe_pkg::CH_LAST: begin
                    o_chunk_bits = {15'd0, r_item.last};
                    o_chunk_len  = 5'd1;
                    o_last_chunk = 1'b1;
                    o_block_done = r_item.done;
                end
                default: begin
                    o_chunk_bits = '0;
                    o_chunk_len  = '0;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= rlhe_pkg::CH_LAST)
        else $error("chunk index past last escape chunk");

    a_idx_esc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_idx != rlhe_pkg::CH_SIGN) |-> r_item.esc)
        else $error("chunk index moved on a single-chunk word");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !fin) |=> (r_idx == $past(r_idx) + 3'd1))
        else $error("escape chunk skipped or repeated");
`endif

endmodule

// File: rtl/run_level_huffman_encoder_unit.sv
// ----------------------------------------------------------------------------
// run_level_huffman_encoder_unit
// Run-level VLC encoder with escape: maps (run, level, last) tuples and
// end-of-stream requests to variable length chunks, LSB first downstream.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   -------  ---  -------------------  ------------------------------------
//   request  in   i_valid / o_ready    i_req_type i_run_length
//                                      i_level_value i_last_flag
//   chunk    out  o_valid / i_ready    o_chunk_bits o_chunk_len
//                                      o_last_chunk o_block_done
//
// one word accepted per cycle when results drain freely; table hits and
// end-of-stream give one chunk, escapes five, one chunk per cycle from the
// result register while i_ready is high, so an escape holds the input until its last chunk is taken
// a request passes the input register and then the result register before its first chunk is valid
// synchronous active-low reset clears valids, chunk index and block position
// a stall on the chunk side backs up into the input register and then o_ready
//
module run_level_huffman_encoder_unit #(
    parameter int BLOCK_COEFS = rlhe_pkg::BLOCK_COEFS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request words
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [6:0]         i_run_length,
    input  logic signed [15:0] i_level_value,
    input  logic               i_last_flag,
    // chunk words
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_chunk_bits,
    output logic [4:0]         o_chunk_len,
    output logic               o_last_chunk,
    output logic               o_block_done
);

    localparam int POS_W = $clog2(BLOCK_COEFS);

    // input register
    logic                r_in_valid, n_in_valid;
    logic                r_req;
    logic [6:0]          r_run;
    logic signed [15:0]  r_level;
    logic                r_last;

    // block position inside the current coefficient block
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    pos_next;

    rlhe_pkg::t_item     item;
    logic                take;
    logic                advance;
    logic                in_acc;

    assign advance = r_in_valid && take;
    assign o_ready = !r_in_valid || take;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        n_pos      = r_pos;
        if (o_ready) begin
            n_in_valid = i_valid;
        end
        if (advance) begin
            n_pos = pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_pos      <= n_pos;
        end
    end

    // payload holds without reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req   <= i_req_type;
            r_run   <= i_run_length;
            r_level <= i_level_value;
            r_last  <= i_last_flag;
        end
    end

    // table match and position update
    rlhe_enc #(
        .BLOCK_COEFS (BLOCK_COEFS)
    ) u_enc (
        .i_req_type    (r_req),
        .i_run_length  (r_run),
        .i_level_value (r_level),
        .i_last_flag   (r_last),
        .i_pos         (r_pos),
        .o_item        (item),
        .o_pos_next    (pos_next)
    );

    // result register and chunk sequencing
    rlhe_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_in_valid),
        .i_item       (item),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chunk_bits (o_chunk_bits),
        .o_chunk_len  (o_chunk_len),
        .o_last_chunk (o_last_chunk),
        .o_block_done (o_block_done)
    );

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(BLOCK_COEFS - 1) || r_pos == POS_W'(BLOCK_COEFS - 1))
        else $error("block position out of range");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_block_done) |-> o_last_chunk)
        else $error("block done on a non-final chunk");

    a_eos_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_req) |=> (r_pos == $past(r_pos)))
        else $error("end-of-stream moved the block position");
`endif

endmodule

// File: dv/tb_run_level_huffman_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_run_level_huffman_encoder_unit
// Self-checking bench for the run-level VLC encoder. Request words go in
// through a valid/ready sender with random gaps, and each one is run through
// a behavioral encoder that queues the chunks it should give. A checker pops
// that queue on every chunk handshake and compares each field. The chunk
// side stalls at random too, except during one long stretch with no gaps.
// ----------------------------------------------------------------------------
module tb_run_level_huffman_encoder_unit;

    // request kinds on i_req_type
    localparam logic REQ_TUPLE = 1'b0;
    localparam logic REQ_EOS   = 1'b1;

    localparam int NUM_CODES    = 9;
    localparam int RANDOM_WORDS = 445;
    localparam int IDLE_PCT     = 37;
    localparam int DRAIN_CYCLES = 20;

    // one table entry: key (run, magnitude, last) and codeword
    typedef struct packed {
        logic [6:0]  run;
        logic [15:0] mag;
        logic        last;
        logic [5:0]  code;
        logic [2:0]  len;
    } t_vlc_entry;

    // one chunk as it should show up on the output
    typedef struct packed {
        logic [15:0] bits;
        logic [4:0]  len;
        logic        last;
        logic        done;
    } t_chunk;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_req_type;
    logic [6:0]         i_run_length;
    logic signed [15:0] i_level_value;
    logic               i_last_flag;
    logic               o_valid;
    logic               i_ready;
    logic [15:0]        o_chunk_bits;
    logic [4:0]         o_chunk_len;
    logic               o_last_chunk;
    logic               o_block_done;

    t_chunk pending_chunks[$];
    int     coef_pos_model;
    int     mismatch_count;
    int     random_sent;
    logic   no_idle;

    run_level_huffman_encoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_run_length (i_run_length),
        .i_level_value(i_level_value),
        .i_last_flag  (i_last_flag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chunk_bits (o_chunk_bits),
        .o_chunk_len  (o_chunk_len),
        .o_last_chunk (o_last_chunk),
        .o_block_done (o_block_done)
    );

    // 10 unit clock, low first
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // the nine data codes, in match priority order
    function automatic t_vlc_entry vlc_entry(input int idx);
        case (idx)
            0:       return {7'd0, 16'd1, 1'b0, 6'h01, 3'd2};
            1:       return {7'd1, 16'd1, 1'b0, 6'h03, 3'd3};
            2:       return {7'd2, 16'd1, 1'b0, 6'h07, 3'd4};
            3:       return {7'd0, 16'd2, 1'b0, 6'h0f, 3'd4};
            4:       return {7'd0, 16'd1, 1'b1, 6'h0e, 3'd4};
            5:       return {7'd3, 16'd1, 1'b0, 6'h16, 3'd5};
            6:       return {7'd4, 16'd1, 1'b0, 6'h06, 3'd5};
            7:       return {7'd5, 16'd1, 1'b0, 6'h1a, 3'd5};
            default: return {7'd0, 16'd3, 1'b0, 6'h2a, 3'd6};
        endcase
    endfunction

    // behavioral encoder: queues the chunks that one accepted word gives
    function automatic void predict_chunks(input logic rt, input logic [6:0] rl,
                                           input logic [15:0] lv, input logic lf);
        t_vlc_entry e;
        logic       sign;
        logic [15:0] mag;
        logic [5:0] run_sent;
        logic       done;
        int         sum;
        int         hit;
        if (rt == REQ_EOS) begin
            // position untouched, other fields don't matter
            pending_chunks.push_back({16'(rlhe_pkg::EOS_CHUNK),
                                      5'(rlhe_pkg::EOS_CHUNK_LEN), 1'b1, 1'b0});
            return;
        end
        sign = lv[15];
        mag  = sign ? 16'(16'd0 - lv) : lv;    // -32768 keeps magnitude 0x8000
        hit  = -1;
        for (int i = 0; i < NUM_CODES; i++) begin
            e = vlc_entry(i);
            if (hit < 0 && rl == e.run && mag == e.mag && lf == e.last)
                hit = i;
        end
        // no wrap on the sum, block closes on last or a full block
        sum  = coef_pos_model + int'(rl) + 1;
        done = lf || (sum >= rlhe_pkg::BLOCK_COEFS_DEF);
        coef_pos_model = done ? 0 : (sum % 64);
        if (hit >= 0) begin
            e = vlc_entry(hit);
            pending_chunks.push_back({16'({e.code, sign}), 5'(e.len) + 5'd1, 1'b1, done});
        end else begin
            run_sent = (rl >= 7'(rlhe_pkg::RUN_SAT)) ? rlhe_pkg::RUN_SAT : rl[5:0];
            pending_chunks.push_back({16'(sign), 5'd1, 1'b0, 1'b0});
            pending_chunks.push_back({16'(rlhe_pkg::ESC_CODE), rlhe_pkg::ESC_LEN,
                                      1'b0, 1'b0});
            pending_chunks.push_back({16'(run_sent), 5'd6, 1'b0, 1'b0});
            pending_chunks.push_back({mag, 5'd16, 1'b0, 1'b0});
            pending_chunks.push_back({16'(lf), 5'd1, 1'b1, done});
        end
    endfunction

    // drive one request word at the falling edge, hold until accepted
    task automatic send_request(input logic rt, input logic [6:0] rl,
                                input logic signed [15:0] lv, input logic lf);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= rt;
        i_run_length  <= rl;
        i_level_value <= lv;
        i_last_flag   <= lf;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_chunks(rt, rl, lv, lf);
    endtask

    // chunk side back pressure, changes at the falling edge
    always @(negedge i_clk)
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    // checker: every chunk handshake against the oldest queued chunk
    always @(posedge i_clk) begin
        t_chunk exp_c;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chunks.size() == 0) begin
                $display("%0t: unexpected chunk bits %h len %0d last %b done %b",
                         $time, o_chunk_bits, o_chunk_len, o_last_chunk, o_block_done);
                mismatch_count++;
            end else begin
                exp_c = pending_chunks.pop_front();
                if (o_chunk_bits !== exp_c.bits) begin
                    $display("%0t: chunk_bits expected %h actual %h",
                             $time, exp_c.bits, o_chunk_bits);
                    mismatch_count++;
                end
                if (o_chunk_len !== exp_c.len) begin
                    $display("%0t: chunk_len expected %0d actual %0d",
                             $time, exp_c.len, o_chunk_len);
                    mismatch_count++;
                end
                if (o_last_chunk !== exp_c.last) begin
                    $display("%0t: last_chunk expected %b actual %b",
                             $time, exp_c.last, o_last_chunk);
                    mismatch_count++;
                end
                if (o_block_done !== exp_c.done) begin
                    $display("%0t: block_done expected %b actual %b",
                             $time, exp_c.done, o_block_done);
                    mismatch_count++;
                end
            end
        end
    end

    // every table entry, signs alternating
    task automatic test_table_hits();
        t_vlc_entry e;
        for (int i = 0; i < NUM_CODES; i++) begin
            e = vlc_entry(i);
            send_request(REQ_TUPLE, e.run, (i % 2) ? -$signed(e.mag) : $signed(e.mag),
                         e.last);
        end
    endtask

    // end of stream with junk in the ignored fields
    task automatic test_end_of_stream();
        send_request(REQ_EOS, 7'd127, -16'sd1, 1'b1);
    endtask

    // misses: reserved runs, long runs, zero and extreme levels, near hits
    task automatic test_escape_cases();
        send_request(REQ_TUPLE, 7'd126, 16'sd1, 1'b0);
        send_request(REQ_TUPLE, 7'd127, -16'sd1, 1'b0);
        send_request(REQ_TUPLE, 7'd64, 16'sd5, 1'b0);
        send_request(REQ_TUPLE, 7'd63, -16'sd2, 1'b0);
        send_request(REQ_TUPLE, 7'd0, 16'sd0, 1'b0);
        send_request(REQ_TUPLE, 7'd0, -16'sd32768, 1'b0);
        send_request(REQ_TUPLE, 7'd6, 16'sd32767, 1'b0);
        send_request(REQ_TUPLE, 7'd0, -16'sd32767, 1'b1);
        send_request(REQ_TUPLE, 7'd0, 16'sd2, 1'b1);    // table key but last set
    endtask

    // position reaching the block size, and end of stream mid block
    task automatic test_block_position();
        send_request(REQ_TUPLE, 7'd0, 16'sd4, 1'b1);    // start from position 0
        send_request(REQ_TUPLE, 7'd30, 16'sd1, 1'b0);
        send_request(REQ_TUPLE, 7'd31, -16'sd1, 1'b0);  // position 63
        send_request(REQ_TUPLE, 7'd0, 16'sd1, 1'b0);    // closes exactly at 64
        send_request(REQ_TUPLE, 7'd10, 16'sd7, 1'b0);
        send_request(REQ_EOS, 7'd0, 16'sd0, 1'b0);
        send_request(REQ_TUPLE, 7'd52, 16'sd1, 1'b0);   // reaches 64 exactly and closes
    endtask

    // mostly well formed blocks, some noise words
    task automatic test_random_blocks();
        int                 blk_len;
        int                 mag;
        logic [6:0]         rl;
        logic signed [15:0] lv;
        while (random_sent < RANDOM_WORDS) begin
            // one long stretch with no gaps on either side
            no_idle = (random_sent >= 150 && random_sent < 260);
            if ($urandom_range(99) < 80) begin
                blk_len = $urandom_range(1, 12);
                for (int k = 0; k < blk_len; k++) begin
                    if ($urandom_range(99) < 85)
                        rl = 7'($urandom_range(0, 6));
                    else
                        rl = 7'($urandom_range(7, 64));
                    if ($urandom_range(99) < 75)
                        mag = $urandom_range(1, 3);
                    else
                        mag = $urandom_range(1, 32767);
                    lv = $urandom_range(1) ? 16'(-mag) : 16'(mag);
                    send_request(REQ_TUPLE, rl, lv, k == blk_len - 1);
                    random_sent++;
                end
                if ($urandom_range(99) < 10) begin
                    send_request(REQ_EOS, 7'($urandom), 16'($urandom), 1'($urandom));
                    random_sent++;
                end
            end else begin
                // noise over the full field ranges
                send_request(($urandom_range(99) < 10) ? REQ_EOS : REQ_TUPLE,
                             7'($urandom), 16'($urandom), 1'($urandom));
                random_sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_req_type     = REQ_TUPLE;
        i_run_length   = '0;
        i_level_value  = '0;
        i_last_flag    = 1'b0;
        no_idle        = 1'b0;
        coef_pos_model = 0;
        mismatch_count = 0;
        random_sent    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_hits();
        test_end_of_stream();
        test_escape_cases();
        test_block_position();
        test_random_blocks();

        @(negedge i_clk);
        i_valid <= 1'b0;
        // drain, then keep watching for stray chunks
        while (pending_chunks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("run_level_huffman_encoder_unit test passed");
        else
            $display("run_level_huffman_encoder_unit test failed");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #2000000;
        $display("run_level_huffman_encoder_unit test failed");
        $finish;
    end

endmodule
